FILE: hdl/ncv3_pkg.sv
// ----------------------------------------------------------------------------
// ncv3_pkg
// Shared widths, command and register codes, and the controller state type
// of the normalized 3D convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncv3_pkg;

	localparam int CMD_W      = 2;
	localparam int LOC_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int SIZE_W     = 6;
	localparam int RADIUS_W   = 2;
	localparam int AXIS_W     = RADIUS_W + 1;
	localparam int COORD_W    = LOC_W + 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int QSHIFT     = 14;

	localparam int RESULT_POS_MAX = 32767;
	localparam int RESULT_NEG_MAG = 32768;

	localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

	localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_VOXEL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;

	localparam logic [SIZE_W-1:0]   SIZE_RESET   = 6'd32;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DIV_X  = 9'b000000010,
		ST_DIV_Y  = 9'b000000100,
		ST_BASE   = 9'b000001000,
		ST_ORIGIN = 9'b000010000,
		ST_SCAN   = 9'b000100000,
		ST_DRAIN  = 9'b001000000,
		ST_DIV_N  = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

FILE: hdl/ncv3_div.sv
// ----------------------------------------------------------------------------
// ncv3_div
// Restoring divider, one quotient bit per cycle. The numerator is taken
// left-aligned; after the requested number of steps the quotient sits in the
// low bits of quo and the remainder in rem. done pulses for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncv3_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 26,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [CNT_W-1:0] steps,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ~diff[DEN_W]};
			rem_q <= diff[DEN_W] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/normalized_3d_convolution.sv
// ----------------------------------------------------------------------------
// normalized_3d_convolution
// Weights and voxels are written into two on-chip memories with load beats.
// A compute beat names an output voxel by linear index; the block splits the
// index into x, y, z with two 15-step divisions, walks the (2r+1)^3 window one
// tap per cycle (one volume read and one weight read per tap inside the
// volume; taps outside the volume are still walked but read nothing), sums
// voxel*weight and the weights, then divides by the weight sum in the shared
// divider, one quotient bit per cycle, or scales by 2^-14 when the weight sum
// is not positive. The accumulator is ACC_W bits wide, where ACC_W = 32 +
// clog2((2*MAX_RADIUS+1)^3 + 1). The window walk and the serial divider set
// the length of a compute. Input is stalled while a compute runs; one
// finished result waits in the output register while loads go on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module normalized_3d_convolution #(
	parameter int MAX_SIDE   = 32,
	parameter int MAX_RADIUS = 3
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ncv3_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ncv3_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  logic [ncv3_pkg::CMD_W-1:0]             command,
	input  logic [ncv3_pkg::LOC_W-1:0]             location,
	input  logic signed [ncv3_pkg::SAMPLE_W-1:0]   sample,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output logic signed [ncv3_pkg::SAMPLE_W-1:0]   filtered_value,
	output logic [ncv3_pkg::LOC_W-1:0]             voxel_index,
	output logic                                   saturated
);

	localparam int KSIDE  = 2 * MAX_RADIUS + 1;
	localparam int WDEPTH = KSIDE * KSIDE * KSIDE;
	localparam int VDEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int VA     = $clog2(VDEPTH);
	localparam int KA     = $clog2(WDEPTH);
	localparam int TAP_W  = $clog2(WDEPTH + 1);
	localparam int ACC_W  = 32 + TAP_W;
	localparam int WSUM_W = 17 + TAP_W;
	localparam int SE_W   = $clog2(MAX_SIDE + 1);
	localparam int CNT_W  = $clog2(ACC_W + 1);
	localparam int CW     = ncv3_pkg::COORD_W;
	localparam int LOC_W  = ncv3_pkg::LOC_W;
	localparam int SMP_W  = ncv3_pkg::SAMPLE_W;
	localparam int AX_W   = ncv3_pkg::AXIS_W;

	function automatic logic [SE_W-1:0] eff_size(input logic [ncv3_pkg::SIZE_W-1:0] v);
		if (v == '0) begin
			return SE_W'(1);
		end else if (int'(v) > MAX_SIDE) begin
			return SE_W'(MAX_SIDE);
		end else begin
			return SE_W'(v);
		end
	endfunction

	ncv3_pkg::state_t state_q, state_d;

	logic [ncv3_pkg::SIZE_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic [ncv3_pkg::RADIUS_W-1:0] radius_q;
	logic [SE_W-1:0]               sx, sy, sz;
	logic [ncv3_pkg::RADIUS_W-1:0] r_eff;
	logic [AX_W-1:0]               win_last;
	logic [CW-1:0]                 r_coord;

	logic req_acc;
	logic is_compute;

	logic signed [SMP_W-1:0] vol_mem [VDEPTH];
	logic signed [SMP_W-1:0] wgt_mem [WDEPTH];
	logic                    vol_we, wgt_we;
	logic [VA-1:0]           vol_wa;
	logic [KA-1:0]           wgt_wa;

	logic [LOC_W-1:0] loc_q;
	logic [CW-1:0]    cx_q;
	logic [CW-1:0]    px0_q, py0_q, pz0_q;
	logic [CW-1:0]    px_q, py_q, pz_q;
	logic [AX_W-1:0]  ix_q, iy_q, iz_q;
	logic [KA-1:0]    ki_q;
	logic [VA-1:0]    sxy_q, plane_base_q, row_off_q, row_base_q;
	logic [VA-1:0]    vi;
	logic             in_x, in_y, in_z;
	logic             last_x, last_y, last_z;
	logic             tap_rd;

	logic                    tap_vld_s1;
	logic signed [SMP_W-1:0] vol_rd_s1, wgt_rd_s1;
	logic                    vld_s2;
	logic signed [31:0]      prod_s2;
	logic signed [SMP_W-1:0] wgt_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [WSUM_W-1:0] wsum_q;
	logic                    drained;

	logic             acc_neg;
	logic [ACC_W-1:0] acc_mag;
	logic             wsum_pos;
	logic             use_div_q;

	logic              div_start, div_busy, div_done;
	logic [ACC_W-1:0]  div_num, div_quo;
	logic [WSUM_W-1:0] div_den, div_rem;
	logic [CNT_W-1:0]  div_steps;

	logic [ACC_W-1:0] q_mag;
	logic             pos_over, neg_over;
	logic [SMP_W-1:0] result;
	logic             rsp_load;
	logic             rsp_valid_q;
	logic [SMP_W-1:0] filtered_q;
	logic [LOC_W-1:0] voxel_q;
	logic             sat_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= ncv3_pkg::SIZE_RESET;
			size_y_q <= ncv3_pkg::SIZE_RESET;
			size_z_q <= ncv3_pkg::SIZE_RESET;
			radius_q <= ncv3_pkg::RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ncv3_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				ncv3_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				ncv3_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				ncv3_pkg::REG_RADIUS: radius_q <= cfg_data[ncv3_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sx       = eff_size(size_x_q);
		sy       = eff_size(size_y_q);
		sz       = eff_size(size_z_q);
		r_eff    = (int'(radius_q) > MAX_RADIUS) ? ncv3_pkg::RADIUS_W'(MAX_RADIUS) : radius_q;
		win_last = {r_eff, 1'b0};
		r_coord  = CW'(r_eff);
	end

	// request side
	assign req_stall  = (state_q != ncv3_pkg::ST_IDLE);
	assign req_acc    = req_valid && !req_stall;
	assign is_compute = (command == ncv3_pkg::CMD_COMPUTE);

	assign vol_we = req_acc && (command == ncv3_pkg::CMD_LOAD_VOXEL) && (int'(location) < VDEPTH);
	assign wgt_we = req_acc && (command == ncv3_pkg::CMD_LOAD_WEIGHT) && (int'(location) < WDEPTH);
	assign vol_wa = VA'(location);
	assign wgt_wa = KA'(location);

	// window walk
	always_comb begin
		in_x   = !px_q[CW-1] && (px_q < CW'(sx));
		in_y   = !py_q[CW-1] && (py_q < CW'(sy));
		in_z   = !pz_q[CW-1] && (pz_q < CW'(sz));
		last_x = (ix_q == win_last);
		last_y = (iy_q == win_last);
		last_z = (iz_q == win_last);
		tap_rd = (state_q == ncv3_pkg::ST_SCAN) && in_x && in_y && in_z;
		vi     = row_base_q + VA'(px_q);
	end

	always_ff @(posedge clk) begin
		if (vol_we) begin
			vol_mem[vol_wa] <= sample;
		end
		if (tap_rd) begin
			vol_rd_s1 <= vol_mem[vi];
		end
	end

	always_ff @(posedge clk) begin
		if (wgt_we) begin
			wgt_mem[wgt_wa] <= sample;
		end
		if (tap_rd) begin
			wgt_rd_s1 <= wgt_mem[ki_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_s1 <= 1'b0;
			vld_s2     <= 1'b0;
		end else begin
			tap_vld_s1 <= tap_rd;
			vld_s2     <= tap_vld_s1;
		end
	end

	assign drained = !tap_vld_s1 && !vld_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= vol_rd_s1 * wgt_rd_s1;
		wgt_s2  <= wgt_rd_s1;
		if (state_q == ncv3_pkg::ST_ORIGIN) begin
			acc_q  <= '0;
			wsum_q <= '0;
		end else if (vld_s2) begin
			acc_q  <= acc_q + ACC_W'(prod_s2);
			wsum_q <= wsum_q + WSUM_W'(wgt_s2);
		end
	end

	always_comb begin
		acc_neg  = acc_q[ACC_W-1];
		acc_mag  = $unsigned(acc_neg ? -acc_q : acc_q);
		wsum_pos = !wsum_q[WSUM_W-1] && (wsum_q != '0);
	end

	// divider operand selection
	always_comb begin
		div_num   = acc_mag;
		div_den   = $unsigned(wsum_q);
		div_steps = CNT_W'(ACC_W);
		div_start = 1'b0;
		case (state_q)
			ncv3_pkg::ST_IDLE: begin
				div_num   = {location, {(ACC_W - LOC_W){1'b0}}};
				div_den   = WSUM_W'(sx);
				div_steps = CNT_W'(LOC_W);
				div_start = req_acc && is_compute;
			end
			ncv3_pkg::ST_DIV_X: begin
				div_num   = {div_quo[LOC_W-1:0], {(ACC_W - LOC_W){1'b0}}};
				div_den   = WSUM_W'(sy);
				div_steps = CNT_W'(LOC_W);
				div_start = div_done;
			end
			ncv3_pkg::ST_DRAIN: begin
				div_start = drained && wsum_pos;
			end
			default: ;
		endcase
	end

	ncv3_div #(
		.NUM_W (ACC_W),
		.DEN_W (WSUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// result
	always_comb begin
		q_mag    = use_div_q ? div_quo : (acc_mag >> ncv3_pkg::QSHIFT);
		pos_over = !acc_neg && (q_mag > ACC_W'(ncv3_pkg::RESULT_POS_MAX));
		neg_over = acc_neg && (q_mag > ACC_W'(ncv3_pkg::RESULT_NEG_MAG));
		if (pos_over) begin
			result = ncv3_pkg::SAT_POS;
		end else if (neg_over) begin
			result = ncv3_pkg::SAT_NEG;
		end else if (acc_neg) begin
			result = SMP_W'(-q_mag[SMP_W-1:0]);
		end else begin
			result = q_mag[SMP_W-1:0];
		end
		rsp_load = (state_q == ncv3_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ncv3_pkg::ST_IDLE:   if (req_acc && is_compute) state_d = ncv3_pkg::ST_DIV_X;
			ncv3_pkg::ST_DIV_X:  if (div_done) state_d = ncv3_pkg::ST_DIV_Y;
			ncv3_pkg::ST_DIV_Y:  if (div_done) state_d = ncv3_pkg::ST_BASE;
			ncv3_pkg::ST_BASE:   state_d = ncv3_pkg::ST_ORIGIN;
			ncv3_pkg::ST_ORIGIN: state_d = ncv3_pkg::ST_SCAN;
			ncv3_pkg::ST_SCAN:   if (last_x && last_y && last_z) state_d = ncv3_pkg::ST_DRAIN;
			ncv3_pkg::ST_DRAIN: begin
				if (drained) begin
					state_d = wsum_pos ? ncv3_pkg::ST_DIV_N : ncv3_pkg::ST_DONE;
				end
			end
			ncv3_pkg::ST_DIV_N:  if (div_done) state_d = ncv3_pkg::ST_DONE;
			ncv3_pkg::ST_DONE:   if (rsp_load) state_d = ncv3_pkg::ST_IDLE;
			default:             state_d = ncv3_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ncv3_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && is_compute) begin
			loc_q <= location;
		end
		if ((state_q == ncv3_pkg::ST_DIV_X) && div_done) begin
			cx_q <= CW'(div_rem);
		end
		if ((state_q == ncv3_pkg::ST_DIV_Y) && div_done) begin
			px0_q <= cx_q - r_coord;
			py0_q <= CW'(div_rem) - r_coord;
			pz0_q <= CW'(div_quo[LOC_W-1:0]) - r_coord;
			sxy_q <= VA'(VA'(sx) * VA'(sy));
		end
		if (state_q == ncv3_pkg::ST_BASE) begin
			plane_base_q <= VA'(sxy_q * VA'($signed(pz0_q)));
			row_off_q    <= VA'(VA'(sx) * VA'($signed(py0_q)));
		end
		if (state_q == ncv3_pkg::ST_ORIGIN) begin
			row_base_q <= plane_base_q + row_off_q;
			px_q       <= px0_q;
			py_q       <= py0_q;
			pz_q       <= pz0_q;
			ix_q       <= '0;
			iy_q       <= '0;
			iz_q       <= '0;
			ki_q       <= '0;
		end
		if (state_q == ncv3_pkg::ST_SCAN) begin
			ki_q <= ki_q + 1'b1;
			if (!last_x) begin
				ix_q <= ix_q + 1'b1;
				px_q <= px_q + 1'b1;
			end else begin
				ix_q <= '0;
				px_q <= px0_q;
				if (!last_y) begin
					iy_q       <= iy_q + 1'b1;
					py_q       <= py_q + 1'b1;
					row_base_q <= row_base_q + VA'(sx);
				end else begin
					iy_q         <= '0;
					py_q         <= py0_q;
					iz_q         <= iz_q + 1'b1;
					pz_q         <= pz_q + 1'b1;
					plane_base_q <= plane_base_q + sxy_q;
					row_base_q   <= plane_base_q + sxy_q + row_off_q;
				end
			end
		end
		if ((state_q == ncv3_pkg::ST_DRAIN) && drained) begin
			use_div_q <= wsum_pos;
		end
		if (rsp_load) begin
			filtered_q <= result;
			voxel_q    <= loc_q;
			sat_q      <= pos_over || neg_over;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign filtered_value = $signed(filtered_q);
	assign voxel_index    = voxel_q;
	assign saturated      = sat_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ncv3_pkg::ST_DONE))
		else $error("result beat raised outside the final step");

	a_acc_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ncv3_pkg::ST_DIV_N || state_q == ncv3_pkg::ST_DONE) |-> drained)
		else $error("tap still in flight after the window walk ended");

	a_tap_in_volume: assert property (@(posedge clk) disable iff (!arst_n)
		tap_rd |-> (int'(vi) < VDEPTH) && (int'(ki_q) < WDEPTH))
		else $error("tap read outside a memory");

endmodule
